FILE: rtl/imhq_pkg.sv
// shared types and codes for the indexed min-heap queue
package imhq_pkg;

    localparam int ITEM_BITS = 10;
    localparam int ITEMS     = 1 << ITEM_BITS;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_UPD  = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_PRESENCE = 2'd3;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [ITEM_BITS-1:0] item;
        logic [31:0]          key;
    } in_t;

    typedef struct packed {
        logic [ITEM_BITS-1:0] popped_item;
        logic [31:0]          popped_key;
        logic [10:0]          occupancy;
        logic [1:0]           status;
    } out_t;

endpackage

FILE: rtl/imhq_ram.sv
// simple dual-port ram, one write and one registered read per cycle
module imhq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/indexed_min_heap_queue.sv
// indexed binary min-heap queue: top level with the command sequencer
// usage: one command word enters on s_ (push, pop, update key) and exactly one
// result word leaves on m_ (popped item and key, occupancy, status).
// the heap lives in a slot memory (item and its key per slot, slots
// 1..CAPACITY); a position memory maps each item to its slot, zero meaning
// absent. every heap step is a registered memory read followed by a compare
// and a write-back, so the sequencer handles one command at a time.
// push / update: the entry climbs level by level while its key is smaller than
// its parent's. pop: the root is taken out, the last entry moves to the root
// and sinks level by level while the smaller child has a smaller key.
// after reset the position memory is cleared, one entry a cycle, through all
// 1024 entries; s_ready stays low until that pass ends.
// the result sits in an output register: a stalled receiver holds it there
// while the next command is accepted and worked on; the sequencer only waits
// when a second result is ready before the first is taken.
module indexed_min_heap_queue #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  imhq_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output imhq_pkg::out_t  m_data
);

    import imhq_pkg::*;

    localparam int SW = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_UP   = 4'd3;
    localparam logic [3:0] ST_UPW  = 4'd4;
    localparam logic [3:0] ST_POPT = 4'd5;
    localparam logic [3:0] ST_POPL = 4'd6;
    localparam logic [3:0] ST_DN   = 4'd7;
    localparam logic [3:0] ST_DNC  = 4'd8;
    localparam logic [3:0] ST_DND  = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;

    typedef struct packed {
        logic [ITEM_BITS-1:0] item;
        logic [KEY_BITS-1:0]  key;
    } entry_t;

    logic [3:0]           state_reg, state_next;
    logic [ITEM_BITS-1:0] clr_reg, clr_next;
    logic [SW-1:0]        fill_reg, fill_next;
    logic [1:0]           cmd_reg, cmd_next;
    // the entry being placed: pushed or updated item, or the last slot on pop
    logic [ITEM_BITS-1:0] item_reg, item_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic [SW-1:0]        c_reg, c_next;
    entry_t               ch_reg, ch_next;
    logic [ITEM_BITS-1:0] pitem_reg, pitem_next;
    logic [31:0]          pkey_reg, pkey_next;
    logic [1:0]           stat_reg, stat_next;
    logic                 mvalid_reg, mvalid_next;
    out_t                 mdata_reg, mdata_next;

    // memory ports
    logic                 h_we;
    logic [SW-1:0]        h_waddr, h_raddr;
    entry_t               h_wdata, h_rdata;
    logic                 p_we;
    logic [ITEM_BITS-1:0] p_waddr, p_raddr;
    logic [SW-1:0]        p_wdata, p_rdata;

    // child selection for the sift-down step
    entry_t               pick;
    logic [SW-1:0]        pick_c;
    logic [SW-1:0]        c_odd;

    imhq_ram #(.DEPTH(CAPACITY + 1), .WIDTH(ITEM_BITS + KEY_BITS)) u_heap (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    imhq_ram #(.DEPTH(ITEMS), .WIDTH(SW)) u_pos (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign c_odd = c_reg | SW'(1);

    // right child wins only when strictly smaller
    always_comb begin
        if (state_reg == ST_DND && h_rdata.key < ch_reg.key) begin
            pick   = h_rdata;
            pick_c = c_odd;
        end else if (state_reg == ST_DND) begin
            pick   = ch_reg;
            pick_c = c_reg;
        end else begin
            pick   = h_rdata;
            pick_c = c_reg;
        end
    end

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        fill_next   = fill_reg;
        cmd_next    = cmd_reg;
        item_next   = item_reg;
        key_next    = key_reg;
        slot_next   = slot_reg;
        c_next      = c_reg;
        ch_next     = ch_reg;
        pitem_next  = pitem_reg;
        pkey_next   = pkey_reg;
        stat_next   = stat_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        s_ready     = 1'b0;
        h_we        = 1'b0;
        h_waddr     = slot_reg;
        h_wdata     = '{item: item_reg, key: key_reg};
        h_raddr     = '0;
        p_we        = 1'b0;
        p_waddr     = item_reg;
        p_wdata     = slot_reg;
        p_raddr     = s_data.item;

        if (m_ready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR: begin
                p_we     = 1'b1;
                p_waddr  = clr_reg;
                p_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ITEM_BITS'(ITEMS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = s_data.cmd;
                    item_next  = s_data.item;
                    key_next   = KEY_BITS'(s_data.key);
                    pitem_next = '0;
                    pkey_next  = '0;
                    stat_next  = STAT_OK;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                unique case (cmd_reg)
                    CMD_PUSH: begin
                        if (p_rdata != '0) begin
                            stat_next  = STAT_PRESENCE;
                            state_next = ST_FIN;
                        end else if (fill_reg == SW'(CAPACITY)) begin
                            stat_next  = STAT_FULL;
                            state_next = ST_FIN;
                        end else begin
                            fill_next  = fill_reg + 1'b1;
                            slot_next  = fill_reg + 1'b1;
                            state_next = ST_UP;
                        end
                    end
                    CMD_POP: begin
                        if (fill_reg == '0) begin
                            stat_next  = STAT_EMPTY;
                            state_next = ST_FIN;
                        end else begin
                            h_raddr    = SW'(1);
                            state_next = ST_POPT;
                        end
                    end
                    CMD_UPD: begin
                        if (p_rdata == '0) begin
                            stat_next  = STAT_PRESENCE;
                            state_next = ST_FIN;
                        end else begin
                            slot_next  = p_rdata;
                            state_next = ST_UP;
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_UP: begin
                if (slot_reg > SW'(1)) begin
                    h_raddr    = slot_reg >> 1;
                    state_next = ST_UPW;
                end else begin
                    h_we       = 1'b1;
                    p_we       = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_UPW: begin
                if (key_reg < h_rdata.key) begin
                    // parent moves down into this slot
                    h_we       = 1'b1;
                    h_wdata    = h_rdata;
                    p_we       = 1'b1;
                    p_waddr    = h_rdata.item;
                    slot_next  = slot_reg >> 1;
                    state_next = ST_UP;
                end else begin
                    h_we       = 1'b1;
                    p_we       = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_POPT: begin
                pitem_next = h_rdata.item;
                pkey_next  = 32'(h_rdata.key);
                p_we       = 1'b1;
                p_waddr    = h_rdata.item;
                p_wdata    = '0;
                fill_next  = fill_reg - 1'b1;
                if (fill_reg == SW'(1)) begin
                    state_next = ST_FIN;
                end else begin
                    h_raddr    = fill_reg;
                    state_next = ST_POPL;
                end
            end
            ST_POPL: begin
                item_next  = h_rdata.item;
                key_next   = h_rdata.key;
                slot_next  = SW'(1);
                state_next = ST_DN;
            end
            ST_DN: begin
                if (slot_reg <= (fill_reg >> 1)) begin
                    c_next     = SW'({slot_reg, 1'b0});
                    h_raddr    = SW'({slot_reg, 1'b0});
                    state_next = ST_DNC;
                end else begin
                    h_we       = 1'b1;
                    p_we       = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_DNC, ST_DND: begin
                if (state_reg == ST_DNC && c_odd <= fill_reg) begin
                    // keep the left child, then fetch the right child
                    ch_next    = h_rdata;
                    h_raddr    = c_odd;
                    state_next = ST_DND;
                end else if (pick.key < key_reg) begin
                    h_we       = 1'b1;
                    h_wdata    = pick;
                    p_we       = 1'b1;
                    p_waddr    = pick.item;
                    slot_next  = pick_c;
                    state_next = ST_DN;
                end else begin
                    h_we       = 1'b1;
                    p_we       = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next            = 1'b1;
                    mdata_next.popped_item = pitem_reg;
                    mdata_next.popped_key  = pkey_reg;
                    mdata_next.occupancy   = 11'(fill_reg);
                    mdata_next.status      = stat_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLR;
            clr_reg    <= '0;
            fill_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            fill_reg   <= fill_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        item_reg  <= item_next;
        key_reg   <= key_next;
        slot_reg  <= slot_next;
        c_reg     <= c_next;
        ch_reg    <= ch_next;
        pitem_reg <= pitem_next;
        pkey_reg  <= pkey_next;
        stat_reg  <= stat_next;
        mdata_reg <= mdata_next;
    end

    assign m_valid = mvalid_reg;
    assign m_data  = mdata_reg;

endmodule
